// ----- sv/rtp_pkg.sv -----
// ----------------------------------------------------------------------------
// rtp_pkg
// Shared types, constants and width helpers for the rigid transform point core.
// ----------------------------------------------------------------------------
package rtp_pkg;

  // Default parameter values
  localparam int COORD_WIDTH_DEF = 32;
  localparam int QUAT_FRAC_DEF   = 14;

  // Fixed field widths
  localparam int QUAT_W     = 16;
  localparam int QC_W       = QUAT_W + 1;  // conjugated component, holds +32768
  localparam int SHIFT_W    = 32;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;

  // Pipeline stages
  localparam int NUM_STAGES = 5;
  localparam int ST_PROD1   = 0;  // v * q products
  localparam int ST_CROSS   = 1;  // t = 2 (q x v), rounded
  localparam int ST_PROD2   = 2;  // t * q products
  localparam int ST_ROT     = 3;  // rotated vector
  localparam int ST_OUT     = 4;  // translate, saturate, output register

  localparam logic [QUAT_W-1:0] ROT_W_RESET = 16'h4000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROT_W   = 4'd0,
    REG_ROT_X   = 4'd1,
    REG_ROT_Y   = 4'd2,
    REG_ROT_Z   = 4'd3,
    REG_SHIFT_X = 4'd4,
    REG_SHIFT_Y = 4'd5,
    REG_SHIFT_Z = 4'd6,
    REG_INVERSE = 4'd7
  } cfg_reg_e;

  typedef logic signed [QC_W-1:0] qcomp_t;

  typedef struct packed {
    qcomp_t w;
    qcomp_t x;
    qcomp_t y;
    qcomp_t z;
  } quat_t;

  // Per-stage load enables from the pipeline control
  typedef struct packed {
    logic [NUM_STAGES-1:0] load;
  } pipe_ctl_t;

  // Width of a rotated coordinate for a given input width and quaternion scale
  function automatic int rot_out_width(input int cw, input int qf);
    int tw;
    int rw;
    tw = cw + QC_W + 1 - qf + 2;
    rw = tw + QC_W + 2 - qf + 1;
    return (cw > rw) ? cw + 1 : rw + 1;
  endfunction

endpackage

// ----- sv/rtp_if.sv -----
// ----------------------------------------------------------------------------
// rtp_if
// Valid/ready channels of the rigid transform point core: points in,
// transformed points out, and register writes.
// ----------------------------------------------------------------------------
interface rtp_in_if #(
  parameter int COORD_WIDTH = rtp_pkg::COORD_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] in_x;
  logic signed [COORD_WIDTH-1:0] in_y;
  logic signed [COORD_WIDTH-1:0] in_z;

  modport source (output valid, in_x, in_y, in_z, input ready);
  modport sink   (input valid, in_x, in_y, in_z, output ready);
endinterface

interface rtp_out_if #(
  parameter int COORD_WIDTH = rtp_pkg::COORD_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] out_x;
  logic signed [COORD_WIDTH-1:0] out_y;
  logic signed [COORD_WIDTH-1:0] out_z;
  logic                          saturated;

  modport source (output valid, out_x, out_y, out_z, saturated, input ready);
  modport sink   (input valid, out_x, out_y, out_z, saturated, output ready);
endinterface

interface rtp_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [rtp_pkg::CFG_IDX_W-1:0]    index;
  logic [rtp_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- sv/rtp_ctrl.sv -----
// ----------------------------------------------------------------------------
// rtp_ctrl
// Valid bits of the pipeline stages and the per-stage load enables. A stage
// loads when it is empty or when the stage after it moves on, so bubbles
// collapse and a stall holds the full stages in place.
// ----------------------------------------------------------------------------
module rtp_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               out_ready_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  output rtp_pkg::pipe_ctl_t ctl_o
);

  localparam int NS = rtp_pkg::NUM_STAGES;

  logic [NS-1:0] valid_q;
  logic [NS-1:0] valid_d;
  logic [NS-1:0] load;

  // Load enables ripple back from the output
  always_comb begin
    load[NS-1] = ~valid_q[NS-1] | out_ready_i;
    for (int k = NS - 2; k >= 0; k--) begin
      load[k] = ~valid_q[k] | load[k+1];
    end
  end

  // Valid bits follow the data
  always_comb begin
    valid_d = valid_q;
    if (load[0]) begin
      valid_d[0] = in_valid_i;
    end
    for (int k = 1; k < NS; k++) begin
      if (load[k]) begin
        valid_d[k] = valid_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign ctl_o.load  = load;
  assign in_ready_o  = load[0];
  assign out_valid_o = valid_q[NS-1];

endmodule

// ----- sv/rtp_rotate.sv -----
// ----------------------------------------------------------------------------
// rtp_rotate
// Four-stage quaternion rotation of a 3D vector:
//   t = 2 (q x v), v' = v + w t + q x t
// with rounding half up after each scaling shift.
// ----------------------------------------------------------------------------
module rtp_rotate #(
  parameter int COORD_WIDTH = rtp_pkg::COORD_WIDTH_DEF,
  parameter int QUAT_FRAC   = rtp_pkg::QUAT_FRAC_DEF
) (
  input  logic                          clk_i,
  input  rtp_pkg::pipe_ctl_t            ctl_i,
  input  rtp_pkg::quat_t                q_i,
  input  logic signed [COORD_WIDTH-1:0] v_i [3],
  output logic signed [rtp_pkg::rot_out_width(COORD_WIDTH, QUAT_FRAC)-1:0] rp_o [3]
);

  localparam int QW  = rtp_pkg::QC_W;
  localparam int P1W = COORD_WIDTH + QW;
  localparam int D1W = P1W + 1;
  localparam int TW  = D1W - QUAT_FRAC + 2;
  localparam int P2W = TW + QW;
  localparam int S2W = P2W + 2;
  localparam int RW  = S2W - QUAT_FRAC + 1;
  localparam int RPW = rtp_pkg::rot_out_width(COORD_WIDTH, QUAT_FRAC);

  logic signed [P1W-1:0]         p1_d [3][2];
  logic signed [P1W-1:0]         p1_q [3][2];
  logic signed [TW-1:0]          t_d  [3];
  logic signed [TW-1:0]          t_q  [3];
  logic signed [P2W-1:0]         p2_d [3][3];
  logic signed [P2W-1:0]         p2_q [3][3];
  logic signed [RPW-1:0]         rp_d [3];
  logic signed [RPW-1:0]         rp_q [3];
  logic signed [COORD_WIDTH-1:0] v0_q [3];
  logic signed [COORD_WIDTH-1:0] v1_q [3];
  logic signed [COORD_WIDTH-1:0] v2_q [3];

  // Stage 0: cross product terms q_b * v_c
  always_comb begin
    p1_d[0][0] = v_i[2] * q_i.y;
    p1_d[0][1] = v_i[1] * q_i.z;
    p1_d[1][0] = v_i[0] * q_i.z;
    p1_d[1][1] = v_i[2] * q_i.x;
    p1_d[2][0] = v_i[1] * q_i.x;
    p1_d[2][1] = v_i[0] * q_i.y;
  end

  // Stage 1: difference, scaled by 2 / 2^QUAT_FRAC with rounding
  always_comb begin
    logic signed [D1W-1:0] diff;
    for (int k = 0; k < 3; k++) begin
      diff   = D1W'(p1_q[k][0]) - D1W'(p1_q[k][1]);
      t_d[k] = TW'(diff >>> (QUAT_FRAC - 1)) + {{(TW-1){1'b0}}, diff[QUAT_FRAC-2]};
    end
  end

  // Stage 2: w t and q x t terms, the third of each row is subtracted
  always_comb begin
    p2_d[0][0] = t_q[0] * q_i.w;
    p2_d[0][1] = t_q[2] * q_i.y;
    p2_d[0][2] = t_q[1] * q_i.z;
    p2_d[1][0] = t_q[1] * q_i.w;
    p2_d[1][1] = t_q[0] * q_i.z;
    p2_d[1][2] = t_q[2] * q_i.x;
    p2_d[2][0] = t_q[2] * q_i.w;
    p2_d[2][1] = t_q[1] * q_i.x;
    p2_d[2][2] = t_q[0] * q_i.y;
  end

  // Stage 3: sum, scale with rounding, add the original vector
  always_comb begin
    logic signed [S2W-1:0] sum;
    logic signed [RW-1:0]  rnd;
    for (int k = 0; k < 3; k++) begin
      sum     = S2W'(p2_q[k][0]) + S2W'(p2_q[k][1]) - S2W'(p2_q[k][2]);
      rnd     = RW'(sum >>> QUAT_FRAC) + {{(RW-1){1'b0}}, sum[QUAT_FRAC-1]};
      rp_d[k] = RPW'(v2_q[k]) + RPW'(rnd);
    end
  end

  // Stage registers, loaded under the pipeline control
  always_ff @(posedge clk_i) begin
    if (ctl_i.load[rtp_pkg::ST_PROD1]) begin
      p1_q <= p1_d;
      v0_q <= v_i;
    end
    if (ctl_i.load[rtp_pkg::ST_CROSS]) begin
      t_q  <= t_d;
      v1_q <= v0_q;
    end
    if (ctl_i.load[rtp_pkg::ST_PROD2]) begin
      p2_q <= p2_d;
      v2_q <= v1_q;
    end
    if (ctl_i.load[rtp_pkg::ST_ROT]) begin
      rp_q <= rp_d;
    end
  end

  assign rp_o = rp_q;

endmodule

// ----- sv/rtp_sat.sv -----
// ----------------------------------------------------------------------------
// rtp_sat
// Final stage: adds the translation (forward) or subtracts the rotated
// translation (inverse), saturates each coordinate and registers the result.
// ----------------------------------------------------------------------------
module rtp_sat #(
  parameter int COORD_WIDTH = rtp_pkg::COORD_WIDTH_DEF,
  parameter int PT_W        = rtp_pkg::rot_out_width(rtp_pkg::COORD_WIDTH_DEF,
                                                     rtp_pkg::QUAT_FRAC_DEF),
  parameter int SH_W        = rtp_pkg::rot_out_width(rtp_pkg::SHIFT_W,
                                                     rtp_pkg::QUAT_FRAC_DEF)
) (
  input  logic                               clk_i,
  input  rtp_pkg::pipe_ctl_t                 ctl_i,
  input  logic                               inverse_i,
  input  logic signed [rtp_pkg::SHIFT_W-1:0] shift_i [3],
  input  logic signed [PT_W-1:0]             rp_pt_i [3],
  input  logic signed [SH_W-1:0]             rp_sh_i [3],
  output logic signed [COORD_WIDTH-1:0]      out_o   [3],
  output logic                               sat_o
);

  localparam int MW = (PT_W > SH_W) ? PT_W : SH_W;
  localparam int XW = (MW > rtp_pkg::SHIFT_W) ? MW : rtp_pkg::SHIFT_W;
  localparam int FW = XW + 1;
  localparam int HW = FW - COORD_WIDTH + 1;

  localparam logic [COORD_WIDTH-1:0] MAX_VAL = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic [COORD_WIDTH-1:0] MIN_VAL = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  logic signed [COORD_WIDTH-1:0] out_d [3];
  logic signed [COORD_WIDTH-1:0] out_q [3];
  logic [2:0]                    clamp;
  logic                          sat_q;

  // Translate and clamp to the coordinate range
  always_comb begin
    logic signed [FW-1:0] sum;
    logic [HW-1:0]        top;
    for (int k = 0; k < 3; k++) begin
      if (inverse_i) begin
        sum = FW'(rp_pt_i[k]) - FW'(rp_sh_i[k]);
      end else begin
        sum = FW'(rp_pt_i[k]) + FW'(shift_i[k]);
      end
      top      = sum[FW-1:COORD_WIDTH-1];
      clamp[k] = ~((&top) | ~(|top));
      if (!clamp[k]) begin
        out_d[k] = sum[COORD_WIDTH-1:0];
      end else if (sum[FW-1]) begin
        out_d[k] = MIN_VAL;
      end else begin
        out_d[k] = MAX_VAL;
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (ctl_i.load[rtp_pkg::ST_OUT]) begin
      out_q <= out_d;
      sat_q <= |clamp;
    end
  end

  assign out_o = out_q;
  assign sat_o = sat_q;

endmodule

// ----- sv/rigid_transform_point_core.sv -----
// ----------------------------------------------------------------------------
// rigid_transform_point_core
// Applies a rotation quaternion plus translation to a stream of 3D points,
// forward or inverse, with saturated fixed-point results.
//
//   channel | modport | moves                          | width
//   --------+---------+--------------------------------+------------------
//   in_i    | sink    | point in_x, in_y, in_z         | 3 x COORD_WIDTH
//   out_o   | source  | out_x, out_y, out_z, saturated | 3 x COORD_WIDTH+1
//   cfg_i   | sink    | register index, write data     | 4 + 32
//
// One point per cycle sustained while out_o is ready; each point passes from its input
// transfer to its result through the five register stages: two product
// stages, the cross term, the rotated sum and the output register.
// The inverse translation is rotated by a second copy of the same pipeline.
// Register writes are taken every cycle; ready on cfg_i is always high.
// Reset clears the stage valid bits and loads the identity transform.
// A stall on out_o holds the full stages next to it; stages behind a bubble
// move on and fill it.
// ----------------------------------------------------------------------------
module rigid_transform_point_core #(
  parameter int COORD_WIDTH = rtp_pkg::COORD_WIDTH_DEF,
  parameter int QUAT_FRAC   = rtp_pkg::QUAT_FRAC_DEF
) (
  input logic    clk_i,
  input logic    rst_ni,
  rtp_in_if.sink    in_i,
  rtp_out_if.source out_o,
  rtp_cfg_if.sink   cfg_i
);

  localparam int QW     = rtp_pkg::QUAT_W;
  localparam int SW     = rtp_pkg::SHIFT_W;
  localparam int PT_RPW = rtp_pkg::rot_out_width(COORD_WIDTH, QUAT_FRAC);
  localparam int SH_RPW = rtp_pkg::rot_out_width(SW, QUAT_FRAC);

  logic signed [QW-1:0]          rot_w_q;
  logic signed [QW-1:0]          rot_x_q;
  logic signed [QW-1:0]          rot_y_q;
  logic signed [QW-1:0]          rot_z_q;
  logic signed [SW-1:0]          shift_q [3];
  logic                          inverse_q;

  rtp_pkg::quat_t                quat;
  rtp_pkg::pipe_ctl_t            ctl;
  logic signed [COORD_WIDTH-1:0] pt_v   [3];
  logic signed [PT_RPW-1:0]      rp_pt  [3];
  logic signed [SH_RPW-1:0]      rp_sh  [3];
  logic signed [COORD_WIDTH-1:0] res    [3];
  logic                          res_sat;
  logic                          in_ready;
  logic                          out_valid;

  // Configuration registers
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_w_q   <= rtp_pkg::ROT_W_RESET;
      rot_x_q   <= '0;
      rot_y_q   <= '0;
      rot_z_q   <= '0;
      shift_q   <= '{default: '0};
      inverse_q <= 1'b0;
    end else if (cfg_i.valid && cfg_i.ready) begin
      unique case (rtp_pkg::cfg_reg_e'(cfg_i.index))
        rtp_pkg::REG_ROT_W:   rot_w_q    <= cfg_i.data[QW-1:0];
        rtp_pkg::REG_ROT_X:   rot_x_q    <= cfg_i.data[QW-1:0];
        rtp_pkg::REG_ROT_Y:   rot_y_q    <= cfg_i.data[QW-1:0];
        rtp_pkg::REG_ROT_Z:   rot_z_q    <= cfg_i.data[QW-1:0];
        rtp_pkg::REG_SHIFT_X: shift_q[0] <= cfg_i.data[SW-1:0];
        rtp_pkg::REG_SHIFT_Y: shift_q[1] <= cfg_i.data[SW-1:0];
        rtp_pkg::REG_SHIFT_Z: shift_q[2] <= cfg_i.data[SW-1:0];
        rtp_pkg::REG_INVERSE: inverse_q  <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  // Quaternion, conjugated in inverse mode
  always_comb begin
    quat.w = rtp_pkg::QC_W'(rot_w_q);
    quat.x = inverse_q ? -rtp_pkg::QC_W'(rot_x_q) : rtp_pkg::QC_W'(rot_x_q);
    quat.y = inverse_q ? -rtp_pkg::QC_W'(rot_y_q) : rtp_pkg::QC_W'(rot_y_q);
    quat.z = inverse_q ? -rtp_pkg::QC_W'(rot_z_q) : rtp_pkg::QC_W'(rot_z_q);
  end

  assign pt_v[0] = in_i.in_x;
  assign pt_v[1] = in_i.in_y;
  assign pt_v[2] = in_i.in_z;

  // Pipeline control
  rtp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .out_ready_i (out_o.ready),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .ctl_o       (ctl)
  );

  // Rotation of the point
  rtp_rotate #(
    .COORD_WIDTH (COORD_WIDTH),
    .QUAT_FRAC   (QUAT_FRAC)
  ) u_rot_pt (
    .clk_i (clk_i),
    .ctl_i (ctl),
    .q_i   (quat),
    .v_i   (pt_v),
    .rp_o  (rp_pt)
  );

  // Rotation of the translation, used in inverse mode
  rtp_rotate #(
    .COORD_WIDTH (SW),
    .QUAT_FRAC   (QUAT_FRAC)
  ) u_rot_sh (
    .clk_i (clk_i),
    .ctl_i (ctl),
    .q_i   (quat),
    .v_i   (shift_q),
    .rp_o  (rp_sh)
  );

  // Translate, saturate, output register
  rtp_sat #(
    .COORD_WIDTH (COORD_WIDTH),
    .PT_W        (PT_RPW),
    .SH_W        (SH_RPW)
  ) u_sat (
    .clk_i     (clk_i),
    .ctl_i     (ctl),
    .inverse_i (inverse_q),
    .shift_i   (shift_q),
    .rp_pt_i   (rp_pt),
    .rp_sh_i   (rp_sh),
    .out_o     (res),
    .sat_o     (res_sat)
  );

  assign in_i.ready      = in_ready;
  assign out_o.valid     = out_valid;
  assign out_o.out_x     = res[0];
  assign out_o.out_y     = res[1];
  assign out_o.out_z     = res[2];
  assign out_o.saturated = res_sat;

endmodule

// ----- sv/rtp_chk.sv -----
// ----------------------------------------------------------------------------
// rtp_chk
// Port-level checks of the rigid transform point core: output stall
// behavior and the count of points in flight against the pipeline depth.
// ----------------------------------------------------------------------------
module rtp_chk #(
  parameter int COORD_WIDTH = rtp_pkg::COORD_WIDTH_DEF
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_ready_i,
  input logic                   out_valid_i,
  input logic                   out_ready_i,
  input logic [COORD_WIDTH-1:0] out_x_i,
  input logic [COORD_WIDTH-1:0] out_y_i,
  input logic [COORD_WIDTH-1:0] out_z_i,
  input logic                   sat_i
);

  localparam int CNT_W = $clog2(rtp_pkg::NUM_STAGES + 1) + 1;

  logic [CNT_W-1:0] cnt_q;
  logic [CNT_W-1:0] cnt_d;
  logic             in_xfer;
  logic             out_xfer;

  // Points in flight
  assign in_xfer  = in_valid_i & in_ready_i;
  assign out_xfer = out_valid_i & out_ready_i;
  assign cnt_d    = cnt_q + CNT_W'(in_xfer) - CNT_W'(out_xfer);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // A stalled result stays
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // A stalled result holds its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable({out_x_i, out_y_i, out_z_i, sat_i}))
    else $error("result changed while stalled");

  // No result without a point in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> cnt_q != '0)
    else $error("result without a matching input");

  // Never more points in flight than stages
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(rtp_pkg::NUM_STAGES))
    else $error("points in flight exceed pipeline depth");

  // An empty pipeline takes input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == '0 |-> in_ready_i)
    else $error("empty pipeline refuses input");

endmodule

bind rigid_transform_point_core rtp_chk #(
  .COORD_WIDTH (COORD_WIDTH)
) u_rtp_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_x_i     (out_o.out_x),
  .out_y_i     (out_o.out_y),
  .out_z_i     (out_o.out_z),
  .sat_i       (out_o.saturated)
);

// ----- test/rigid_transform_point_core_tb.sv -----
// ----------------------------------------------------------------------------
// rigid_transform_point_core_tb
// Streams 3D points through the rigid transform core under a series of
// quaternion, translation and direction settings and checks every result,
// including the saturation flag, against a fixed-point predictor kept here.
// Both channels idle at random; the output side also holds off for a long
// stretch so the pipeline backs up into the input.
// ----------------------------------------------------------------------------
module rigid_transform_point_core_tb;

  localparam int CW             = rtp_pkg::COORD_WIDTH_DEF;
  localparam int QF             = rtp_pkg::QUAT_FRAC_DEF;
  localparam int QUAT_W         = rtp_pkg::QUAT_W;
  localparam int SHIFT_W        = rtp_pkg::SHIFT_W;
  localparam int CFG_IDX_W      = rtp_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W     = rtp_pkg::CFG_DATA_W;
  localparam int CFRAC          = 16;
  localparam longint COORD_MAX  = (longint'(1) <<< (CW - 1)) - 1;
  localparam longint COORD_MIN  = -COORD_MAX - 1;
  localparam logic [CW-1:0] PMAX  = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] PMIN  = {1'b1, {(CW-1){1'b0}}};
  localparam logic [CW-1:0] ONE_Q = CW'(1) << CFRAC;
  localparam int NUM_PHASES     = 12;
  localparam int PHASE_ITEMS    = 100;
  localparam int LONG_HOLD      = 80;
  localparam int DRAIN_CYCLES   = 4 * rtp_pkg::NUM_STAGES;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } point_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    logic                 sat;
  } xform_t;

  // Register copy, transform predictor and queue of expected points
  class xform_scoreboard;
    logic [QUAT_W-1:0]  quat [4];
    logic [SHIFT_W-1:0] trans [3];
    logic               inverse;
    xform_t             expected_q [$];
    int                 results_checked;
    int                 mismatches;

    function new();
      quat[0] = rtp_pkg::ROT_W_RESET;
      quat[1] = '0;
      quat[2] = '0;
      quat[3] = '0;
      trans[0] = '0;
      trans[1] = '0;
      trans[2] = '0;
      inverse = 1'b0;
      results_checked = 0;
      mismatches = 0;
    endfunction

    // Unknown indexes leave everything alone
    function void write_reg(logic [CFG_IDX_W-1:0] idx,
                            logic [CFG_DATA_W-1:0] data);
      unique case (idx)
        rtp_pkg::REG_ROT_W:   quat[0] = data[QUAT_W-1:0];
        rtp_pkg::REG_ROT_X:   quat[1] = data[QUAT_W-1:0];
        rtp_pkg::REG_ROT_Y:   quat[2] = data[QUAT_W-1:0];
        rtp_pkg::REG_ROT_Z:   quat[3] = data[QUAT_W-1:0];
        rtp_pkg::REG_SHIFT_X: trans[0] = data[SHIFT_W-1:0];
        rtp_pkg::REG_SHIFT_Y: trans[1] = data[SHIFT_W-1:0];
        rtp_pkg::REG_SHIFT_Z: trans[2] = data[SHIFT_W-1:0];
        rtp_pkg::REG_INVERSE: inverse = data[0];
        default: ;
      endcase
    endfunction

    // Divide by 2^s, ties go toward +infinity
    function longint round_half_up(longint a, int s);
      return (a + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    // t = 2 (q x v), v' = v + w t + q x t
    function void rotate(input longint q [4], input longint v [3],
                         output longint r [3]);
      longint t [3];
      longint s [3];
      t[0] = round_half_up(q[2] * v[2] - q[3] * v[1], QF - 1);
      t[1] = round_half_up(q[3] * v[0] - q[1] * v[2], QF - 1);
      t[2] = round_half_up(q[1] * v[1] - q[2] * v[0], QF - 1);
      s[0] = t[0] * q[0] + t[2] * q[2] - t[1] * q[3];
      s[1] = t[1] * q[0] + t[0] * q[3] - t[2] * q[1];
      s[2] = t[2] * q[0] + t[1] * q[1] - t[0] * q[2];
      for (int i = 0; i < 3; i++)
        r[i] = v[i] + round_half_up(s[i], QF);
    endfunction

    function logic [CW-1:0] clamp(longint a, inout logic flag);
      if (a > COORD_MAX) begin
        flag = 1'b1;
        return CW'(COORD_MAX);
      end
      if (a < COORD_MIN) begin
        flag = 1'b1;
        return CW'(COORD_MIN);
      end
      return CW'(a);
    endfunction

    function xform_t transform(point_t p);
      longint q [4];
      longint v [3];
      longint sh [3];
      longint rp [3];
      longint rs [3];
      logic   flag;
      xform_t res;
      for (int i = 0; i < 4; i++)
        q[i] = longint'($signed(quat[i]));
      // conjugate; -32768 turns into +32768 exactly
      if (inverse)
        for (int i = 1; i < 4; i++)
          q[i] = -q[i];
      v[0] = longint'($signed(p.x));
      v[1] = longint'($signed(p.y));
      v[2] = longint'($signed(p.z));
      for (int i = 0; i < 3; i++)
        sh[i] = longint'($signed(trans[i]));
      rotate(q, v, rp);
      if (inverse) begin
        rotate(q, sh, rs);
        for (int i = 0; i < 3; i++)
          rp[i] = rp[i] - rs[i];
      end else begin
        for (int i = 0; i < 3; i++)
          rp[i] = rp[i] + sh[i];
      end
      flag = 1'b0;
      res.x = clamp(rp[0], flag);
      res.y = clamp(rp[1], flag);
      res.z = clamp(rp[2], flag);
      res.sat = flag;
      return res;
    endfunction

    function void note_point(point_t p);
      expected_q.push_back(transform(p));
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      $display("result %0d: %s", results_checked, msg);
    endtask

    task check_result(xform_t got);
      xform_t want;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("no point pending, got %0d %0d %0d sat %0b",
                                  got.x, got.y, got.z, got.sat));
      end else begin
        want = expected_q.pop_front();
        if (got.x !== want.x)
          report_mismatch($sformatf("out_x expected %0d, got %0d", want.x, got.x));
        if (got.y !== want.y)
          report_mismatch($sformatf("out_y expected %0d, got %0d", want.y, got.y));
        if (got.z !== want.z)
          report_mismatch($sformatf("out_z expected %0d, got %0d", want.z, got.z));
        if (got.sat !== want.sat)
          report_mismatch($sformatf("saturated expected %0b, got %0b", want.sat, got.sat));
      end
      results_checked++;
    endtask
  endclass

  logic clk;
  logic rst_n;

  rtp_in_if  #(.COORD_WIDTH(CW)) pt_if ();
  rtp_out_if #(.COORD_WIDTH(CW)) res_if ();
  rtp_cfg_if                     cfg_if ();

  rigid_transform_point_core #(
    .COORD_WIDTH (CW),
    .QUAT_FRAC   (QF)
  ) uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (pt_if),
    .out_o  (res_if),
    .cfg_i  (cfg_if)
  );

  xform_scoreboard sb;
  int              points_sent;
  bit              steady;
  bit              hold_request;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Mostly back to back, some short gaps, a few long ones
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic point_t mk_point(logic [CW-1:0] x, logic [CW-1:0] y, logic [CW-1:0] z);
    point_t p;
    p.x = x;
    p.y = y;
    p.z = z;
    return p;
  endfunction

  function automatic logic [CW-1:0] rand_coord();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return CW'($urandom);
    if (r < 7) return CW'(int'($urandom_range(0, 1 << 19)) - (1 << 18));
    if (r < 8) begin
      case ($urandom_range(0, 4))
        0:       return PMAX;
        1:       return PMIN;
        2:       return CW'(1);
        3:       return CW'(-1);
        default: return '0;
      endcase
    end
    return CW'(int'($urandom_range(0, 16)) - 8);
  endfunction

  function automatic point_t rand_point();
    return mk_point(rand_coord(), rand_coord(), rand_coord());
  endfunction

  function automatic logic [QUAT_W-1:0] quat_comp(int kind);
    case (kind)
      // multiples of 2^12 land on rounding ties often
      0: return QUAT_W'(4096 * (int'($urandom_range(0, 15)) - 8));
      1: return QUAT_W'($urandom);
      2: return QUAT_W'(int'($urandom_range(0, 32768)) - 16384);
      default: begin
        case ($urandom_range(0, 4))
          0:       return {1'b1, {(QUAT_W-1){1'b0}}};
          1:       return {1'b0, {(QUAT_W-1){1'b1}}};
          2:       return QUAT_W'(16384);
          3:       return QUAT_W'(-16384);
          default: return '0;
        endcase
      end
    endcase
  endfunction

  function automatic logic [SHIFT_W-1:0] shift_val(int kind);
    case (kind)
      0: return SHIFT_W'($urandom);
      1: return SHIFT_W'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
      default: begin
        case ($urandom_range(0, 2))
          0:       return PMAX;
          1:       return PMIN;
          default: return '0;
        endcase
      end
    endcase
  endfunction

  // Random bits above the register width
  function automatic logic [CFG_DATA_W-1:0] pad_junk(logic [CFG_DATA_W-1:0] v, int width);
    logic [CFG_DATA_W-1:0] mask;
    mask = (CFG_DATA_W'(1) << width) - 1;
    return (CFG_DATA_W'($urandom) & ~mask) | (v & mask);
  endfunction

  // Leaves valid up so back-to-back writes need no extra edge
  task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk); while (!cfg_if.ready);
  endtask

  task automatic apply_setting(logic [QUAT_W-1:0] w, logic [QUAT_W-1:0] x,
                               logic [QUAT_W-1:0] y, logic [QUAT_W-1:0] z,
                               logic [SHIFT_W-1:0] sx, logic [SHIFT_W-1:0] sy,
                               logic [SHIFT_W-1:0] sz, logic inv);
    logic [CFG_IDX_W-1:0] junk_idx;
    put_reg(rtp_pkg::REG_ROT_W, pad_junk(CFG_DATA_W'(w), QUAT_W));
    put_reg(rtp_pkg::REG_ROT_X, pad_junk(CFG_DATA_W'(x), QUAT_W));
    put_reg(rtp_pkg::REG_ROT_Y, pad_junk(CFG_DATA_W'(y), QUAT_W));
    put_reg(rtp_pkg::REG_ROT_Z, pad_junk(CFG_DATA_W'(z), QUAT_W));
    put_reg(rtp_pkg::REG_SHIFT_X, CFG_DATA_W'(sx));
    put_reg(rtp_pkg::REG_SHIFT_Y, CFG_DATA_W'(sy));
    put_reg(rtp_pkg::REG_SHIFT_Z, CFG_DATA_W'(sz));
    put_reg(rtp_pkg::REG_INVERSE, pad_junk(CFG_DATA_W'(inv), 1));
    // a write to an unused index must change nothing
    junk_idx = CFG_IDX_W'($urandom_range(rtp_pkg::REG_INVERSE + 1, (1 << CFG_IDX_W) - 1));
    put_reg(junk_idx, CFG_DATA_W'($urandom));
    cfg_if.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (sb.results_checked < points_sent) @(posedge clk);
  endtask

  task automatic send_point(point_t p);
    int gap;
    gap = steady ? 0 : idle_len();
    if (gap > 0) begin
      pt_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pt_if.valid <= 1'b1;
    pt_if.in_x  <= p.x;
    pt_if.in_y  <= p.y;
    pt_if.in_z  <= p.z;
    do @(posedge clk); while (!pt_if.ready);
    points_sent++;
  endtask

  // pause_at: stop and wait for every result; hold_at: ask the output side
  // for a long hold-off while points keep coming
  task automatic stream(point_t pts [$], int pause_at, int hold_at);
    for (int i = 0; i < pts.size(); i++) begin
      if (i == pause_at && i > 0) begin
        pt_if.valid <= 1'b0;
        wait_drained();
      end
      if (i == hold_at)
        hold_request = 1'b1;
      send_point(pts[i]);
    end
    pt_if.valid <= 1'b0;
    wait_drained();
  endtask

  // Output ready: random stalls, or a long hold on request
  initial begin
    int stall_left;
    res_if.ready = 1'b0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        stall_left = LONG_HOLD;
      end
      if (stall_left > 0) begin
        res_if.ready <= 1'b0;
        stall_left--;
      end else begin
        res_if.ready <= 1'b1;
        if (!steady) stall_left = idle_len();
      end
    end
  end

  // Transfer monitor
  always @(posedge clk) begin
    if (rst_n) begin
      if (pt_if.valid && pt_if.ready)
        sb.note_point(mk_point(pt_if.in_x, pt_if.in_y, pt_if.in_z));
      if (res_if.valid && res_if.ready)
        sb.check_result({res_if.out_x, res_if.out_y, res_if.out_z, res_if.saturated});
      if (cfg_if.valid && cfg_if.ready)
        sb.write_reg(cfg_if.index, cfg_if.data);
    end
  end

  // Watchdog: too long without any transfer
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((pt_if.valid && pt_if.ready) || (res_if.valid && res_if.ready) ||
          (cfg_if.valid && cfg_if.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    point_t            pts [$];
    logic [QUAT_W-1:0]  qv [4];
    logic [SHIFT_W-1:0] sv [3];
    int                 qkind;
    int                 skind;

    sb = new();
    rst_n        = 1'b0;
    pt_if.valid  = 1'b0;
    pt_if.in_x   = '0;
    pt_if.in_y   = '0;
    pt_if.in_z   = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data  = '0;
    steady       = 1'b0;
    hold_request = 1'b0;
    points_sent  = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Identity transform straight out of reset
    pts.push_back(mk_point('0, '0, '0));
    pts.push_back(mk_point(PMAX, PMIN, '0));
    pts.push_back(mk_point(PMAX, PMAX, PMAX));
    pts.push_back(mk_point(PMIN, PMIN, PMIN));
    pts.push_back(mk_point(CW'(1), CW'(-1), ONE_Q));
    stream(pts, -1, -1);

    // All components -32768, inverse: conjugate needs +32768, saturates hard
    apply_setting({1'b1, {(QUAT_W-1){1'b0}}}, {1'b1, {(QUAT_W-1){1'b0}}},
                  {1'b1, {(QUAT_W-1){1'b0}}}, {1'b1, {(QUAT_W-1){1'b0}}},
                  PMAX, PMIN, PMAX, 1'b1);
    pts.delete();
    pts.push_back(mk_point('0, '0, '0));
    pts.push_back(mk_point(PMAX, PMAX, PMAX));
    pts.push_back(mk_point(PMIN, PMIN, PMIN));
    pts.push_back(mk_point(ONE_Q, -ONE_Q, CW'(1)));
    stream(pts, -1, -1);

    // Largest positive non-unit quaternion, forward, extreme shifts
    apply_setting({1'b0, {(QUAT_W-1){1'b1}}}, {1'b0, {(QUAT_W-1){1'b1}}},
                  {1'b0, {(QUAT_W-1){1'b1}}}, {1'b0, {(QUAT_W-1){1'b1}}},
                  PMIN, PMAX, '0, 1'b0);
    pts.delete();
    pts.push_back(mk_point('0, '0, '0));
    pts.push_back(mk_point(PMAX, PMAX, PMAX));
    pts.push_back(mk_point(PMIN, PMIN, PMIN));
    pts.push_back(mk_point(CW'(-1), CW'(2), CW'(-3)));
    stream(pts, -1, -1);

    // Quarter turn about z, forward then inverse on the same points
    pts.delete();
    pts.push_back(mk_point(ONE_Q, '0, '0));
    pts.push_back(mk_point('0, ONE_Q, '0));
    pts.push_back(mk_point('0, '0, ONE_Q));
    pts.push_back(mk_point(-ONE_Q, ONE_Q >> 1, CW'(7)));
    apply_setting(QUAT_W'(11585), '0, '0, QUAT_W'(11585), ONE_Q, ONE_Q << 1, -ONE_Q, 1'b0);
    stream(pts, -1, -1);
    apply_setting(QUAT_W'(11585), '0, '0, QUAT_W'(11585), ONE_Q, ONE_Q << 1, -ONE_Q, 1'b1);
    stream(pts, -1, -1);

    // Coarse quaternion on tiny points: rounding ties in both stages
    apply_setting('0, QUAT_W'(4096), QUAT_W'(-4096), QUAT_W'(8192), '0, '0, '0, 1'b0);
    pts.delete();
    pts.push_back(mk_point(CW'(1), CW'(1), CW'(1)));
    pts.push_back(mk_point(CW'(1), CW'(2), CW'(3)));
    pts.push_back(mk_point(CW'(-1), CW'(-2), CW'(-3)));
    pts.push_back(mk_point(CW'(3), CW'(-5), CW'(7)));
    stream(pts, -1, -1);

    // Random settings, each with a batch of random points
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      qkind = $urandom_range(0, 3);
      skind = $urandom_range(0, 2);
      for (int i = 0; i < 4; i++)
        qv[i] = quat_comp(qkind);
      for (int i = 0; i < 3; i++)
        sv[i] = shift_val(skind);
      steady = 1'b0;
      apply_setting(qv[0], qv[1], qv[2], qv[3], sv[0], sv[1], sv[2], 1'(phase % 2));
      steady = (phase % 4 == 1);
      pts.delete();
      for (int i = 0; i < PHASE_ITEMS; i++)
        pts.push_back(rand_point());
      stream(pts, (phase % 3 == 0) ? PHASE_ITEMS / 2 : -1,
             (phase == 1 || phase == 5) ? 20 : -1);
    end

    steady = 1'b0;
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/rtp_pkg.sv
sv/rtp_if.sv
sv/rtp_ctrl.sv
sv/rtp_rotate.sv
sv/rtp_sat.sv
sv/rigid_transform_point_core.sv
sv/rtp_chk.sv
test/rigid_transform_point_core_tb.sv
